// File: src/chbs_pkg.sv
// ----------------------------------------------------------------------------
// chbs_pkg
// Shared widths and register indexes for the corner height box sum block.
// ----------------------------------------------------------------------------
package chbs_pkg;

    localparam int DIM_W           = 11;    // grid_width / grid_height registers
    localparam int ROW_W           = 10;    // row counter
    localparam int POS_W           = 11;    // corner_row / corner_col
    localparam int MAX_GRID_HEIGHT = 1024;
    localparam int CFG_IDX_W       = 1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_GRID_WIDTH  = 1'b0;
    localparam cfg_idx_t REG_GRID_HEIGHT = 1'b1;

endpackage

// File: src/chbs_if.sv
// ----------------------------------------------------------------------------
// chbs_if
// Valid/ready channels of the corner height box sum block: cell input,
// corner output and configuration write.
// ----------------------------------------------------------------------------
interface chbs_cell_if #(
    parameter int HEIGHT_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [HEIGHT_BITS-1:0] height;

    modport source (output valid, output height, input ready);
    modport sink   (input valid, input height, output ready);
endinterface

interface chbs_corner_if
    import chbs_pkg::*;
#(
    parameter int HEIGHT_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [HEIGHT_BITS+1:0] corner_sum;
    logic [POS_W-1:0]       corner_row;
    logic [POS_W-1:0]       corner_col;
    logic                   frame_end;

    modport source (output valid, output corner_sum, output corner_row,
                    output corner_col, output frame_end, input ready);
    modport sink   (input valid, input corner_sum, input corner_row,
                    input corner_col, input frame_end, output ready);
endinterface

interface chbs_cfg_if
    import chbs_pkg::*;
;
    logic             valid;
    logic             ready;
    cfg_idx_t         index;
    logic [DIM_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/corner_height_box_sum_top.sv
// ----------------------------------------------------------------------------
// corner_height_box_sum_top
// 2x2 box sum over a raster height map with replicated borders, producing
// the (rows+1) x (cols+1) corner grid.
// ----------------------------------------------------------------------------
// Cells enter in raster order, one word per cycle while cells.ready is
// high. A cell yields one corner, a row-end or last-row cell two, and the
// last cell of the map four; a new cell is taken only as stage 1 hands on
// the last corner of the current one. The output register delivers one
// corner word per cycle unless stalled. A cell's first corner passes
// the stage 1 registers, then the output register. The row store is a
// single-port read-first memory of MAX_GRID_WIDTH cells with a registered
// read; it has no clearing pass and row 0 ignores its output. Configuration
// is always ready and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module corner_height_box_sum_top
    import chbs_pkg::*;
#(
    parameter int MAX_GRID_WIDTH = 1024,
    parameter int HEIGHT_BITS    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    chbs_cell_if.sink     cells,
    chbs_corner_if.source corners,
    chbs_cfg_if.sink      cfg
);

    localparam int AW    = (MAX_GRID_WIDTH > 1) ? $clog2(MAX_GRID_WIDTH) : 1;
    localparam int HB    = HEIGHT_BITS;
    localparam int SUM_W = HEIGHT_BITS + 2;

    typedef enum logic [1:0] {
        RES_MAIN   = 2'd0,
        RES_BOTTOM = 2'd1,
        RES_RIGHT  = 2'd2,
        RES_CORNER = 2'd3
    } res_kind_t;

    // configuration
    logic [DIM_W-1:0] grid_width_reg;
    logic [DIM_W-1:0] grid_height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_W'(1);
            grid_height_reg <= DIM_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg.data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // clamped last column / last row
    logic [AW-1:0]    wm1;
    logic [ROW_W-1:0] hm1;

    always_comb
    begin
        if (grid_width_reg == '0)
            wm1 = '0;
        else if (32'(grid_width_reg) > MAX_GRID_WIDTH)
            wm1 = AW'(MAX_GRID_WIDTH - 1);
        else
            wm1 = AW'(grid_width_reg - DIM_W'(1));

        if (grid_height_reg == '0)
            hm1 = '0;
        else if (32'(grid_height_reg) > MAX_GRID_HEIGHT)
            hm1 = ROW_W'(MAX_GRID_HEIGHT - 1);
        else
            hm1 = ROW_W'(grid_height_reg - DIM_W'(1));
    end

    // stage 0: position, left neighbour, row store access
    logic [AW-1:0]    col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [HB-1:0]    left_reg;
    logic             in_accept;
    logic             row_end;
    logic             last_row;
    logic [AW-1:0]    c0;
    logic [ROW_W-1:0] r0;
    logic [HB-1:0]    l0;

    assign in_accept = cells.valid && cells.ready;
    assign row_end   = (col_cnt_reg >= wm1);
    assign last_row  = (row_cnt_reg >= hm1);
    assign c0        = row_end ? wm1 : col_cnt_reg;
    assign r0        = last_row ? hm1 : row_cnt_reg;
    assign l0        = (c0 != '0) ? left_reg : cells.height;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            left_reg    <= '0;
        end
        else if (in_accept)
        begin
            left_reg <= cells.height;
            if (row_end)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row ? '0 : r0 + ROW_W'(1);
            end
            else
            begin
                col_cnt_reg <= c0 + AW'(1);
            end
        end
    end

    logic [HB-1:0] row_mem [MAX_GRID_WIDTH];
    logic [HB-1:0] up_reg;

    // read-first: the cell above is fetched as this one overwrites it
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            up_reg      <= row_mem[c0];
            row_mem[c0] <= cells.height;
        end
    end

    // stage 1: one item, expanded into its corners
    logic             s1_valid_reg;
    logic [HB-1:0]    s1_a_reg;
    logic [HB-1:0]    s1_l_reg;
    logic [AW-1:0]    s1_c_reg;
    logic [ROW_W-1:0] s1_r_reg;
    logic             s1_row_end_reg;
    logic             s1_last_row_reg;
    logic [1:0]       sub_reg;
    logic [HB-1:0]    ul_reg;

    logic             out_free;
    logic             s1_fire;
    logic             s1_last;
    logic [1:0]       last_sub;
    logic [HB-1:0]    u1;
    logic [HB-1:0]    ul1;
    res_kind_t        kind;
    logic [SUM_W-1:0] sum_next;
    logic [POS_W-1:0] row_next;
    logic [POS_W-1:0] col_next;
    logic             fe_next;
    logic             row_inc;
    logic             col_inc;

    assign out_free  = !corners.valid || corners.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign last_sub  = {s1_row_end_reg & s1_last_row_reg, s1_row_end_reg | s1_last_row_reg};
    assign s1_last   = (sub_reg == last_sub);
    assign cells.ready = !s1_valid_reg || (s1_fire && s1_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sub_reg      <= '0;
            ul_reg       <= '0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire && s1_last)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                sub_reg <= s1_last ? 2'd0 : sub_reg + 2'd1;

            if (s1_fire && s1_last)
                ul_reg <= up_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_a_reg        <= cells.height;
            s1_l_reg        <= l0;
            s1_c_reg        <= c0;
            s1_r_reg        <= r0;
            s1_row_end_reg  <= row_end;
            s1_last_row_reg <= last_row;
        end
    end

    always_comb
    begin
        u1  = (s1_r_reg != '0) ? up_reg : s1_a_reg;
        ul1 = (s1_r_reg != '0) ? ((s1_c_reg != '0) ? ul_reg : u1) : s1_l_reg;

        case (sub_reg)
            2'd0:    kind = RES_MAIN;
            2'd1:    kind = s1_last_row_reg ? RES_BOTTOM : RES_RIGHT;
            2'd2:    kind = RES_RIGHT;
            default: kind = RES_CORNER;
        endcase

        row_inc = 1'b0;
        col_inc = 1'b0;
        fe_next = 1'b0;
        unique case (kind)
            RES_MAIN:
            begin
                sum_next = SUM_W'(s1_a_reg) + SUM_W'(s1_l_reg) + SUM_W'(u1) + SUM_W'(ul1);
            end
            RES_BOTTOM:
            begin
                sum_next = (SUM_W'(s1_a_reg) + SUM_W'(s1_l_reg)) << 1;
                row_inc  = 1'b1;
            end
            RES_RIGHT:
            begin
                sum_next = (SUM_W'(s1_a_reg) + SUM_W'(u1)) << 1;
                col_inc  = 1'b1;
            end
            RES_CORNER:
            begin
                sum_next = SUM_W'(s1_a_reg) << 2;
                row_inc  = 1'b1;
                col_inc  = 1'b1;
                fe_next  = 1'b1;
            end
            default:
            begin
                sum_next = '0;
            end
        endcase

        row_next = POS_W'(s1_r_reg) + POS_W'(row_inc);
        col_next = POS_W'(32'(s1_c_reg) + 32'(col_inc));
    end

    // output register
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic [POS_W-1:0] out_row_reg;
    logic [POS_W-1:0] out_col_reg;
    logic             out_fe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (corners.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_sum_reg <= sum_next;
            out_row_reg <= row_next;
            out_col_reg <= col_next;
            out_fe_reg  <= fe_next;
        end
    end

    assign corners.valid      = out_valid_reg;
    assign corners.corner_sum = out_sum_reg;
    assign corners.corner_row = out_row_reg;
    assign corners.corner_col = out_col_reg;
    assign corners.frame_end  = out_fe_reg;

endmodule

// File: src/chbs_checker.sv
// ----------------------------------------------------------------------------
// chbs_checker
// Port-level checks on the corner height box sum block, bound to its top.
// ----------------------------------------------------------------------------
module chbs_checker
    import chbs_pkg::*;
#(
    parameter int HEIGHT_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [HEIGHT_BITS+1:0] corner_sum,
    input logic [POS_W-1:0]       corner_row,
    input logic [POS_W-1:0]       corner_col,
    input logic                   frame_end
);

    // a stalled corner word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("corner word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(corner_sum) && $stable(corner_row)
                                    && $stable(corner_col) && $stable(frame_end))
        else $error("corner word changed while stalled");

    // the closing corner is the bottom-right one: four times one cell
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> corner_sum[1:0] == 2'b00
                                   && corner_row != '0 && corner_col != '0)
        else $error("frame end on a corner that is not bottom-right");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready && $past(cfg_ready))
        else $error("configuration port not ready");

endmodule

bind corner_height_box_sum_top chbs_checker #(
    .HEIGHT_BITS (HEIGHT_BITS)
) u_chbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ready  (cfg.ready),
    .out_valid  (corners.valid),
    .out_ready  (corners.ready),
    .corner_sum (corners.corner_sum),
    .corner_row (corners.corner_row),
    .corner_col (corners.corner_col),
    .frame_end  (corners.frame_end)
);
